@@ design/trt_pkg.sv @@
package trt_pkg;

    localparam int SRC_W    = 16;
    localparam int SEQ_W    = 32;
    localparam int MSS_W    = 16;
    localparam int STATUS_W = 3;
    localparam int DRAIN_W  = 7;

    localparam logic [MSS_W-1:0] MSS_RESET = 16'd512;

    typedef enum logic [STATUS_W-1:0] {
        STAT_IN_ORDER  = 3'd0,
        STAT_AHEAD     = 3'd1,
        STAT_OLD       = 3'd2,
        STAT_WRONG_SRC = 3'd3,
        STAT_OVERFLOW  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIMIT,
        S_CLASS,
        S_DIV,
        S_DRAIN,
        S_MARK,
        S_OUT
    } t_state;

endpackage

@@ design/trt_if.sv @@
interface trt_in_if import trt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SRC_W-1:0] source_id;
    logic [SEQ_W-1:0] segment_seq;

    modport source (output valid, output source_id, output segment_seq, input ready);
    modport sink   (input valid, input source_id, input segment_seq, output ready);
endinterface

interface trt_out_if import trt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    next_expected;
    logic [DRAIN_W-1:0]  drained_count;

    modport source (output valid, output status, output next_expected,
                    output drained_count, input ready);
    modport sink   (input valid, input status, input next_expected,
                    input drained_count, output ready);
endinterface

interface trt_cfg_if import trt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MSS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/tcp_receive_reassembly_tracker.sv @@
// Sequence: accept, S_LIMIT, S_CLASS, then S_OUT for a wrong source, an old duplicate or a
// window overflow; a stored-ahead segment goes S_DIV, S_MARK, S_OUT; an in-order one goes S_DIV,
// then S_DRAIN releases one buffered segment per step and re-runs S_DIV when the sequence wraps.
// One segment at a time: the next beat is taken only after the result is accepted; the 32-step
// shared restoring divider that finds the slot index, plus the drain walk, sets the pace.
// Reset (synchronous, active low): unbound, expectation zero, bitmap clear, segment size 512.
module tcp_receive_reassembly_tracker
    import trt_pkg::*;
#(
    parameter int WINDOW_SEGMENTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    trt_cfg_if.sink         i_cfg,
    trt_in_if.sink          i_seg,
    trt_out_if.source       o_res
);

    localparam int SW  = $clog2(WINDOW_SEGMENTS);
    localparam int CW  = $clog2(WINDOW_SEGMENTS + 1);
    localparam int CDW = (CW > DRAIN_W) ? CW : DRAIN_W;
    localparam int LW  = MSS_W + SW;
    localparam int DW  = (LW > SEQ_W) ? LW : SEQ_W;
    localparam logic [LW-1:0]  WIN_M1   = LW'(WINDOW_SEGMENTS - 1);
    localparam logic [SW:0]    WIN_EXT  = (SW+1)'(WINDOW_SEGMENTS);
    localparam logic [SW-1:0]  SLOT_MAX = SW'(WINDOW_SEGMENTS - 1);
    localparam logic [CW-1:0]  CNT_MAX  = CW'(WINDOW_SEGMENTS);
    localparam logic [4:0]     DIV_LAST = 5'(SEQ_W - 1);

    // control state
    t_state                 r_state, n_state;
    logic [SRC_W-1:0]       r_bound, n_bound;
    logic [SEQ_W-1:0]       r_exp, n_exp;
    logic [WINDOW_SEGMENTS-1:0] r_map, n_map;
    logic [MSS_W-1:0]       r_mss;

    // payload and working registers
    logic [SEQ_W-1:0]       r_seq, n_seq;
    logic                   r_wrong, n_wrong;
    logic [SEQ_W-1:0]       r_dist, n_dist;
    logic [LW-1:0]          r_limit, n_limit;
    logic                   r_ahead, n_ahead;
    logic [4:0]             r_cnt, n_cnt;
    logic [SEQ_W-1:0]       r_dvd, n_dvd;
    logic [MSS_W-1:0]       r_rem, n_rem;
    logic [SW-1:0]          r_slot, n_slot;
    logic [CW-1:0]          r_drained, n_drained;
    t_status                r_status, n_status;

    logic [MSS_W-1:0]       mss_eff;
    logic                   seg_beat;
    logic [SRC_W-1:0]       bound_eff;
    logic [MSS_W:0]         div_t;
    logic                   div_ge;
    logic [SW:0]            qm2;
    logic [SEQ_W:0]         exp_sum;
    logic                   drain_hit;
    logic [CDW-1:0]         drained_ext;

    assign mss_eff  = (r_mss == '0) ? MSS_W'(1) : r_mss;
    assign seg_beat = i_seg.valid && i_seg.ready;
    assign bound_eff = (r_bound == '0) ? i_seg.source_id : r_bound;

    // shared divider step: one quotient bit, quotient kept modulo the window
    assign div_t  = {r_rem, r_dvd[SEQ_W-1]};
    assign div_ge = div_t >= {1'b0, mss_eff};
    assign qm2    = {r_slot, div_ge};

    assign exp_sum   = {1'b0, r_exp} + {{(SEQ_W-MSS_W+1){1'b0}}, mss_eff};
    assign drain_hit = r_map[r_slot] && (r_drained != CNT_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (seg_beat) n_state = S_LIMIT;
            S_LIMIT: n_state = S_CLASS;
            S_CLASS: begin
                if (r_wrong) begin
                    n_state = S_OUT;
                end else if (r_dist == '0) begin
                    n_state = S_DIV;
                end else if (!r_dist[SEQ_W-1]) begin
                    n_state = (DW'(r_dist) > DW'(r_limit)) ? S_OUT : S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV:   if (r_cnt == DIV_LAST) n_state = r_ahead ? S_MARK : S_DRAIN;
            S_DRAIN: begin
                if (!drain_hit) n_state = S_OUT;
                else if (exp_sum[SEQ_W]) n_state = S_DIV;
            end
            S_MARK:  n_state = S_OUT;
            S_OUT:   if (o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_bound   = r_bound;
        n_exp     = r_exp;
        n_map     = r_map;
        n_seq     = r_seq;
        n_wrong   = r_wrong;
        n_dist    = r_dist;
        n_limit   = r_limit;
        n_ahead   = r_ahead;
        n_cnt     = r_cnt;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_slot    = r_slot;
        n_drained = r_drained;
        n_status  = r_status;
        case (r_state)
            S_IDLE: begin
                // take the beat and bind on first sight
                if (seg_beat) begin
                    if (r_bound == '0) n_bound = i_seg.source_id;
                    n_wrong = bound_eff != i_seg.source_id;
                    n_seq   = i_seg.segment_seq;
                end
            end
            S_LIMIT: begin
                n_limit   = WIN_M1 * LW'(mss_eff);
                n_dist    = r_seq - r_exp;
                n_drained = '0;
            end
            S_CLASS: begin
                n_cnt  = '0;
                n_rem  = '0;
                n_slot = '0;
                if (r_wrong) begin
                    n_status = STAT_WRONG_SRC;
                end else if (r_dist == '0) begin
                    // advance, then find the slot of the new expectation
                    n_exp    = exp_sum[SEQ_W-1:0];
                    n_dvd    = exp_sum[SEQ_W-1:0];
                    n_ahead  = 1'b0;
                    n_status = STAT_IN_ORDER;
                end else if (!r_dist[SEQ_W-1]) begin
                    if (DW'(r_dist) > DW'(r_limit)) begin
                        n_status = STAT_OVERFLOW;
                    end else begin
                        n_dvd    = r_seq;
                        n_ahead  = 1'b1;
                        n_status = STAT_AHEAD;
                    end
                end else begin
                    n_status = STAT_OLD;
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? MSS_W'(div_t - {1'b0, mss_eff}) : div_t[MSS_W-1:0];
                n_slot = (qm2 >= WIN_EXT) ? SW'(qm2 - WIN_EXT) : qm2[SW-1:0];
                n_dvd  = {r_dvd[SEQ_W-2:0], 1'b0};
                n_cnt  = r_cnt + 5'd1;
            end
            S_DRAIN: begin
                // release one buffered segment and step to the next slot, or re-divide after a sequence wrap
                if (drain_hit) begin
                    n_map[r_slot] = 1'b0;
                    n_exp         = exp_sum[SEQ_W-1:0];
                    n_drained     = r_drained + CW'(1);
                    if (exp_sum[SEQ_W]) begin
                        n_dvd  = exp_sum[SEQ_W-1:0];
                        n_cnt  = '0;
                        n_rem  = '0;
                        n_slot = '0;
                    end else begin
                        n_slot = (r_slot == SLOT_MAX) ? '0 : r_slot + SW'(1);
                    end
                end
            end
            S_MARK:  n_map[r_slot] = 1'b1;
            S_OUT:   ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bound <= '0;
            r_exp   <= '0;
            r_map   <= '0;
            r_mss   <= MSS_RESET;
        end else begin
            r_state <= n_state;
            r_bound <= n_bound;
            r_exp   <= n_exp;
            r_map   <= n_map;
            if (i_cfg.valid && i_cfg.ready) r_mss <= i_cfg.data;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_wrong   <= n_wrong;
        r_dist    <= n_dist;
        r_limit   <= n_limit;
        r_ahead   <= n_ahead;
        r_cnt     <= n_cnt;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_slot    <= n_slot;
        r_drained <= n_drained;
        r_status  <= n_status;
    end

    assign drained_ext = CDW'(r_drained);

    // outputs
    always_comb begin
        i_cfg.ready         = 1'b1;
        i_seg.ready         = r_state == S_IDLE;
        o_res.valid         = r_state == S_OUT;
        o_res.status        = r_status;
        o_res.next_expected = r_exp;
        o_res.drained_count = (drained_ext > CDW'(127)) ? DRAIN_W'(127)
                                                        : drained_ext[DRAIN_W-1:0];
    end

endmodule

@@ design/trt_checker.sv @@
module trt_checker
    import trt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [DRAIN_W-1:0]  i_drained
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before its beat");

    // no new segment while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while result pending");

    // busy right after a segment beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready again right after a segment beat");

    // only in-order arrivals release buffered segments
    a_drain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != STAT_IN_ORDER) |-> i_drained == '0)
        else $error("drain count on a non in-order result");

endmodule

bind tcp_receive_reassembly_tracker trt_checker u_trt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_seg.valid),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_drained   (o_res.drained_count)
);

@@ tb/tcp_receive_reassembly_tracker_tb.sv @@
module tcp_receive_reassembly_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trt_pkg::*;

    localparam int TRK_WINDOW = 64;
    localparam logic [SRC_W-1:0] HOST_ID = 16'h1234;
    localparam int PHASE_ITEMS = 156;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        t_status             status;
        logic [SEQ_W-1:0]    next_exp;
        logic [DRAIN_W-1:0]  drained;
    } t_ack;

    typedef struct {
        logic [SRC_W-1:0] src;
        logic [SEQ_W-1:0] seq;
        bit               typed;
        t_ack             ack;
    } t_seg_row;

    logic i_clk;
    logic i_rst_n;

    trt_cfg_if cfg_bus ();
    trt_in_if  seg_bus ();
    trt_out_if res_bus ();

    tcp_receive_reassembly_tracker #(
        .WINDOW_SEGMENTS(TRK_WINDOW)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_seg  (seg_bus),
        .o_res  (res_bus)
    );

    // Tracker state mirrored on the bench side
    logic [MSS_W-1:0]      mss_reg  = MSS_RESET;
    logic [SRC_W-1:0]      peer     = '0;
    logic [SEQ_W-1:0]      rcv_next = '0;
    logic [TRK_WINDOW-1:0] ooo_map  = '0;

    t_ack ack_q[$];
    int   errors = 0;
    bit   steady = 1'b0;

    // Opening segments at the reset segment size of 512
    t_seg_row opening [17] = '{
        // source zero while unbound stays unbound and is processed
        '{16'h0000, 32'h0000_0000, 1'b1, '{STAT_IN_ORDER,  32'd512,  7'd0}},
        // first real source binds
        '{HOST_ID,  32'd512,       1'b1, '{STAT_IN_ORDER,  32'd1024, 7'd0}},
        '{16'hFFFF, 32'd1024,      1'b1, '{STAT_WRONG_SRC, 32'd1024, 7'd0}},
        '{16'h0000, 32'd1024,      1'b1, '{STAT_WRONG_SRC, 32'd1024, 7'd0}},
        '{HOST_ID,  32'hFFFF_FFFF, 1'b1, '{STAT_OLD,       32'd1024, 7'd0}},
        '{HOST_ID,  32'h0000_0000, 1'b1, '{STAT_OLD,       32'd1024, 7'd0}},
        // last slot inside the window, then one byte past it
        '{HOST_ID,  32'd33280,     1'b1, '{STAT_AHEAD,     32'd1024, 7'd0}},
        '{HOST_ID,  32'd33281,     1'b1, '{STAT_OVERFLOW,  32'd1024, 7'd0}},
        // half-range boundary of the modular compare
        '{HOST_ID,  32'h8000_03FF, 1'b1, '{STAT_OVERFLOW,  32'd1024, 7'd0}},
        '{HOST_ID,  32'h8000_0400, 1'b1, '{STAT_OLD,       32'd1024, 7'd0}},
        '{HOST_ID,  32'd1536,      1'b0, '0},
        '{HOST_ID,  32'd2048,      1'b0, '0},
        // not a multiple of the segment size: floor division picks the slot
        '{HOST_ID,  32'd2660,      1'b0, '0},
        // fills the hole and releases the three buffered slots
        '{HOST_ID,  32'd1024,      1'b0, '0},
        '{HOST_ID,  32'd3073,      1'b0, '0},
        '{HOST_ID,  32'd3072,      1'b0, '0},
        '{16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0}
    };

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [SEQ_W-1:0] step_size();
        return (mss_reg == '0) ? 32'd1 : {16'd0, mss_reg};
    endfunction

    function automatic int slot_for(logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] idx;
        idx = seq / step_size();
        return int'(idx % TRK_WINDOW);
    endfunction

    // Advance the tracker by one segment and return the acknowledgment it yields
    function automatic t_ack track_segment(logic [SRC_W-1:0] src, logic [SEQ_W-1:0] seq);
        t_ack             a;
        logic [SEQ_W-1:0] m;
        logic [SEQ_W-1:0] delta;
        int               n;
        m = step_size();
        a.drained = '0;
        if (peer == '0)
            peer = src;
        if (peer != src) begin
            a.status = STAT_WRONG_SRC;
        end else begin
            delta = seq - rcv_next;
            if (delta == '0) begin
                a.status = STAT_IN_ORDER;
                rcv_next = rcv_next + m;
                // release consecutive buffered slots
                for (n = 0; n < TRK_WINDOW; n++) begin
                    if (!ooo_map[slot_for(rcv_next)])
                        break;
                    ooo_map[slot_for(rcv_next)] = 1'b0;
                    rcv_next = rcv_next + m;
                    a.drained = a.drained + 7'd1;
                end
            end else if (delta < 32'h8000_0000) begin
                if (64'(delta) > 64'(TRK_WINDOW - 1) * 64'(m)) begin
                    a.status = STAT_OVERFLOW;
                end else begin
                    a.status = STAT_AHEAD;
                    ooo_map[slot_for(seq)] = 1'b1;
                end
            end else begin
                a.status = STAT_OLD;
            end
        end
        a.next_exp = rcv_next;
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Present one segment beat, predict at acceptance, then maybe idle
    task automatic send_segment(logic [SRC_W-1:0] src, logic [SEQ_W-1:0] seq,
                                bit typed, t_ack typed_ack);
        t_ack a;
        int   gap;
        seg_bus.valid       <= 1'b1;
        seg_bus.source_id   <= src;
        seg_bus.segment_seq <= seq;
        @(posedge i_clk);
        while (!seg_bus.ready)
            @(posedge i_clk);
        a = track_segment(src, seq);
        ack_q.push_back(typed ? typed_ack : a);
        gap = pick_gap();
        if (gap > 0) begin
            seg_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every pending acknowledgment is back
    task automatic settle_acks();
        seg_bus.valid <= 1'b0;
        while (ack_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mss(logic [MSS_W-1:0] value);
        settle_acks();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        mss_reg = value;
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly well-formed traffic around the expectation, some noise
    task automatic send_random();
        logic [SRC_W-1:0] src;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] m;
        int               pick;
        m    = step_size();
        src  = (peer == '0) ? HOST_ID : peer;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            seq = rcv_next;
        else if (pick < 65)
            seq = rcv_next + m * $urandom_range(1, TRK_WINDOW - 1);
        else if (pick < 72)
            seq = rcv_next + m * $urandom_range(TRK_WINDOW, TRK_WINDOW + 16);
        else if (pick < 80)
            seq = rcv_next - m * $urandom_range(1, TRK_WINDOW);
        else if (pick < 86)
            seq = $urandom;
        else if (pick < 93)
            seq = rcv_next + m * $urandom_range(0, TRK_WINDOW - 2) + $urandom_range(0, m - 1);
        else if (pick < 97) begin
            src = SRC_W'($urandom);
            seq = $urandom;
        end else begin
            src = '0;
            seq = rcv_next;
        end
        send_segment(src, seq, 1'b0, '0);
    endtask

    // Result sink: random backpressure with long open stretches
    initial begin
        int hold;
        int stall;
        res_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 8);
            stall = steady ? 0 : ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                               : $urandom_range(15, 60);
            res_bus.ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Compare each result beat with the oldest pending acknowledgment
    always @(posedge i_clk) begin
        t_ack want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (ack_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d next %0h drained %0d",
                    res_bus.status, res_bus.next_expected, res_bus.drained_count));
            end else begin
                want = ack_q.pop_front();
                if (res_bus.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                        res_bus.status, want.status));
                if (res_bus.next_expected !== want.next_exp)
                    report_mismatch($sformatf("next_expected got %0h want %0h",
                        res_bus.next_expected, want.next_exp));
                if (res_bus.drained_count !== want.drained)
                    report_mismatch($sformatf("drained_count got %0d want %0d",
                        res_bus.drained_count, want.drained));
            end
        end
    end

    // Main sequence
    initial begin
        logic [MSS_W-1:0] sizes [8];
        i_rst_n             = 1'b0;
        seg_bus.valid       = 1'b0;
        seg_bus.source_id   = '0;
        seg_bus.segment_seq = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.data        = '0;

        // zero size acts as one; extremes first, then mixed values
        sizes = '{16'd0, 16'd1, 16'hFFFF, 16'd1500, 16'd2,
                  16'($urandom), 16'($urandom_range(3, 300)), MSS_RESET};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i])
            send_segment(opening[i].src, opening[i].seq, opening[i].typed, opening[i].ack);

        foreach (sizes[p]) begin
            write_mss(sizes[p]);
            steady = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    settle_acks();
                send_random();
            end
        end
        steady = 1'b0;

        settle_acks();
        repeat (150) @(posedge i_clk);
        if (errors == 0 && ack_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
